// ===== rtl/all_pairs_shortest_path_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH
`define ALL_PAIRS_SHORTEST_PATH_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define APSP_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check.
`define APSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define APSP_ASSERT(label, clk, rst, ante, cons, msg)
`define APSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/apsp_pkg.sv =====
package apsp_pkg;

   // Field widths
   localparam int MODE_W   = 2;
   localparam int VTX_W    = 3;
   localparam int WEIGHT_W = 16;
   localparam int LEN_W    = 48;
   localparam int VCNT_W   = 4;

   localparam int MAX_VERTICES_DEF = 8;
   localparam logic [VCNT_W-1:0] VCNT_RESET = 4'd8;

   // Saturation bounds of a path length
   localparam logic signed [LEN_W-1:0] LEN_MAX = {1'b0, {(LEN_W-1){1'b1}}};
   localparam logic signed [LEN_W-1:0] LEN_MIN = {1'b1, {(LEN_W-1){1'b0}}};

   // Request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_RUN   = 2'd2
   } mode_type;

   // Datapath actions of one control word
   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_ACCEPT   = 4'd1,
      OP_RD_EDGE  = 4'd2,
      OP_WR_EDGE  = 4'd3,
      OP_INIT     = 4'd4,
      OP_RD_IKKJ  = 4'd5,
      OP_SUM      = 4'd6,
      OP_WR_RELAX = 4'd7,
      OP_RD_DIAG  = 4'd8,
      OP_ADV_I    = 4'd9,
      OP_EMIT     = 4'd10,
      OP_EMIT_NEG = 4'd11
   } op_type;

   // Jump conditions of one control word
   typedef enum logic [3:0] {
      C_NEVER   = 4'd0,
      C_ALWAYS  = 4'd1,
      C_NOACC   = 4'd2,
      C_NOTLOAD = 4'd3,
      C_NOTRUN  = 4'd4,
      C_EDGEOUT = 4'd5,
      C_MORE3   = 4'd6,
      C_NEG     = 4'd7,
      C_MOREI   = 4'd8,
      C_BUSY    = 4'd9,
      C_MORE    = 4'd10
   } cond_type;

   localparam int STEP_W = 5;
   typedef logic [STEP_W-1:0] step_type;

   // Program addresses
   localparam step_type STEP_IDLE   = 5'd0;
   localparam step_type STEP_DISP   = 5'd1;
   localparam step_type STEP_LD_RD  = 5'd2;
   localparam step_type STEP_LD_WR  = 5'd3;
   localparam step_type STEP_INIT   = 5'd4;
   localparam step_type STEP_FW_RD  = 5'd5;
   localparam step_type STEP_FW_SUM = 5'd6;
   localparam step_type STEP_FW_WR  = 5'd7;
   localparam step_type STEP_DG_RD  = 5'd8;
   localparam step_type STEP_DG_CHK = 5'd9;
   localparam step_type STEP_DG_ADV = 5'd10;
   localparam step_type STEP_EM_RD  = 5'd11;
   localparam step_type STEP_EM_OUT = 5'd12;
   localparam step_type STEP_EM_NXT = 5'd13;
   localparam step_type STEP_EM_END = 5'd14;
   localparam step_type STEP_NG_OUT = 5'd15;
   localparam step_type STEP_NG_END = 5'd16;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   function automatic ucode_type uword(input op_type op, input cond_type cond,
                                       input step_type target);
      ucode_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // Control program: jump to target when the condition holds, else fall through
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      unique case (step)
         STEP_IDLE:   w = uword(OP_ACCEPT,   C_NOACC,   STEP_IDLE);
         STEP_DISP:   w = uword(OP_NONE,     C_NOTLOAD, STEP_INIT);
         STEP_LD_RD:  w = uword(OP_RD_EDGE,  C_EDGEOUT, STEP_IDLE);
         STEP_LD_WR:  w = uword(OP_WR_EDGE,  C_ALWAYS,  STEP_IDLE);
         STEP_INIT:   w = uword(OP_INIT,     C_NOTRUN,  STEP_IDLE);
         STEP_FW_RD:  w = uword(OP_RD_IKKJ,  C_NEVER,   STEP_IDLE);
         STEP_FW_SUM: w = uword(OP_SUM,      C_NEVER,   STEP_IDLE);
         STEP_FW_WR:  w = uword(OP_WR_RELAX, C_MORE3,   STEP_FW_RD);
         STEP_DG_RD:  w = uword(OP_RD_DIAG,  C_NEVER,   STEP_IDLE);
         STEP_DG_CHK: w = uword(OP_NONE,     C_NEG,     STEP_NG_OUT);
         STEP_DG_ADV: w = uword(OP_ADV_I,    C_MOREI,   STEP_DG_RD);
         STEP_EM_RD:  w = uword(OP_NONE,     C_NEVER,   STEP_IDLE);
         STEP_EM_OUT: w = uword(OP_EMIT,     C_BUSY,    STEP_EM_OUT);
         STEP_EM_NXT: w = uword(OP_NONE,     C_MORE,    STEP_EM_RD);
         STEP_EM_END: w = uword(OP_NONE,     C_ALWAYS,  STEP_IDLE);
         STEP_NG_OUT: w = uword(OP_EMIT_NEG, C_BUSY,    STEP_NG_OUT);
         STEP_NG_END: w = uword(OP_NONE,     C_ALWAYS,  STEP_IDLE);
         default:     w = uword(OP_NONE,     C_ALWAYS,  STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/apsp_req_if.sv =====
interface apsp_req_if;
   import apsp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic [VTX_W-1:0]           source_vertex;
   logic [VTX_W-1:0]           dest_vertex;
   logic signed [WEIGHT_W-1:0] edge_weight;

   modport source (output valid, mode, source_vertex, dest_vertex, edge_weight,
                   input ready);
   modport sink   (input valid, mode, source_vertex, dest_vertex, edge_weight,
                   output ready);
endinterface

// ===== rtl/apsp_rsp_if.sv =====
interface apsp_rsp_if;
   import apsp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [VTX_W-1:0]        row_vertex;
   logic [VTX_W-1:0]        col_vertex;
   logic signed [LEN_W-1:0] path_length;
   logic                    unreachable;
   logic                    negative_cycle;
   logic                    last;

   modport source (output valid, row_vertex, col_vertex, path_length, unreachable,
                   negative_cycle, last, input ready);
   modport sink   (input valid, row_vertex, col_vertex, path_length, unreachable,
                   negative_cycle, last, output ready);
endinterface

// ===== rtl/all_pairs_shortest_path.sv =====
// Channel   Dir  Word
// req_if    in   mode, source_vertex, dest_vertex, edge_weight
// rsp_if    out  row_vertex, col_vertex, path_length, unreachable, negative_cycle, last
// csr_*     in   vertex_count write (csr_wr_en, csr_wr_data)
//
// Clear or unused-mode word: accept, dispatch, init. Edge word: accept, dispatch, then read and
// compare-write through the matrix RAM; the write is skipped when a vertex is out of range.
// Run word with n vertices: n^3 relax passes (read ik/kj, add, compare-write), a diagonal check
// per vertex, then read, emit and next for each entry, or a lone negative-cycle word instead.
// Reset (synchronous) clears the entry valid bits, so the matrix reads back cleared at once.
// A stalled rsp_if holds the sequencer in its emit step; req_if is ready only when idle.
`include "all_pairs_shortest_path_defines.svh"

module all_pairs_shortest_path #(
   parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   apsp_req_if.sink                      req_if,
   apsp_rsp_if.source                    rsp_if,
   input  logic                          csr_wr_en,
   input  logic [apsp_pkg::VCNT_W-1:0]   csr_wr_data
);
   import apsp_pkg::*;

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int AW    = 2 * VW;
   localparam int DEPTH = 1 << AW;

   // Sequencer
   step_type  step_ff;
   step_type  step_in;
   ucode_type uw;
   logic      jump;

   // Vertex counters
   logic [VW-1:0] i_ff, j_ff, k_ff;
   logic [VW-1:0] i_in, j_in, k_in;
   logic          done_ff, done_in;

   // Configuration
   logic [VCNT_W-1:0] vcnt_ff;
   logic [VCNT_W-1:0] n_eff;
   logic [VW-1:0]     last_idx;
   logic              i_last, j_last, k_last;

   // Latched request word
   logic [MODE_W-1:0]          mode_ff;
   logic [VTX_W-1:0]           u_ff, v_ff;
   logic signed [WEIGHT_W-1:0] w_ff;
   logic signed [LEN_W-1:0]    w_ext;
   logic                       req_accept;

   // Matrix RAM and entry valid bits
   logic signed [LEN_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]        vld_ff;
   logic [AW-1:0]           addr_a, addr_b, mem_waddr;
   logic                    mem_we;
   logic signed [LEN_W-1:0] mem_wdata;
   logic signed [LEN_W-1:0] a_raw_ff, b_raw_ff;
   logic                    a_vld_ff, b_vld_ff, a_diag_ff, b_diag_ff;
   logic                    a_inf, b_inf;
   logic signed [LEN_W-1:0] a_len, b_len;

   // Relax sum
   logic signed [LEN_W:0]   sum_full;
   logic signed [LEN_W-1:0] sum_sat, sum_ff;
   logic                    sum_ok_ff;

   // Result register
   logic                    rsp_valid_ff;
   logic                    out_free, out_load;
   logic [VTX_W-1:0]        row_ff, col_ff;
   logic signed [LEN_W-1:0] len_ff;
   logic                    unr_ff, neg_ff, last_ff;

   // Effective vertex count and last index
   always_comb begin
      if (vcnt_ff == '0) begin
         n_eff = VCNT_W'(1);
      end else if (vcnt_ff > VCNT_W'(MAX_VERTICES)) begin
         n_eff = VCNT_W'(MAX_VERTICES);
      end else begin
         n_eff = vcnt_ff;
      end
   end

   assign last_idx = VW'(n_eff - VCNT_W'(1));
   assign i_last   = (i_ff == last_idx);
   assign j_last   = (j_ff == last_idx);
   assign k_last   = (k_ff == last_idx);

   // Fetch control word
   assign uw = ucode_rom(step_ff);

   assign req_if.ready = (uw.op == OP_ACCEPT);
   assign req_accept   = req_if.valid && req_if.ready;
   assign w_ext        = {{(LEN_W-WEIGHT_W){w_ff[WEIGHT_W-1]}}, w_ff};

   // Unwritten entries read as infinite, diagonal as zero
   assign a_inf = !a_vld_ff && !a_diag_ff;
   assign b_inf = !b_vld_ff && !b_diag_ff;
   assign a_len = a_vld_ff ? a_raw_ff : '0;
   assign b_len = b_vld_ff ? b_raw_ff : '0;

   // Saturating add of ik and kj
   assign sum_full = {a_len[LEN_W-1], a_len} + {b_len[LEN_W-1], b_len};
   always_comb begin
      if (sum_full[LEN_W] != sum_full[LEN_W-1]) begin
         sum_sat = sum_full[LEN_W] ? LEN_MIN : LEN_MAX;
      end else begin
         sum_sat = sum_full[LEN_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Evaluate jump condition
   always_comb begin
      unique case (uw.cond)
         C_NEVER:   jump = 1'b0;
         C_ALWAYS:  jump = 1'b1;
         C_NOACC:   jump = !req_accept;
         C_NOTLOAD: jump = (mode_ff != MODE_LOAD);
         C_NOTRUN:  jump = (mode_ff != MODE_RUN);
         C_EDGEOUT: jump = (VCNT_W'(u_ff) >= n_eff) || (VCNT_W'(v_ff) >= n_eff);
         C_MORE3:   jump = !(i_last && j_last && k_last);
         C_NEG:     jump = !a_inf && a_len[LEN_W-1];
         C_MOREI:   jump = !i_last;
         C_BUSY:    jump = !out_free;
         C_MORE:    jump = !done_ff;
         default:   jump = 1'b0;
      endcase
   end

   assign step_in = jump ? uw.target : step_type'(step_ff + 1'b1);

   // RAM addressing and write decode
   always_comb begin
      addr_a    = {i_ff, j_ff};
      addr_b    = {k_ff, j_ff};
      mem_we    = 1'b0;
      mem_waddr = {i_ff, j_ff};
      mem_wdata = sum_ff;
      unique case (uw.op)
         OP_RD_EDGE: addr_a = {u_ff[VW-1:0], v_ff[VW-1:0]};
         OP_RD_IKKJ: addr_a = {i_ff, k_ff};
         OP_RD_DIAG: addr_a = {i_ff, i_ff};
         OP_WR_EDGE: begin
            mem_waddr = {u_ff[VW-1:0], v_ff[VW-1:0]};
            mem_wdata = w_ext;
            mem_we    = a_inf || (w_ext < a_len);
         end
         OP_WR_RELAX: begin
            mem_we = sum_ok_ff && (a_inf || (sum_ff < a_len));
         end
         default: ;
      endcase
   end

   // Counter advance
   always_comb begin
      i_in    = i_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      done_in = done_ff;
      out_load = 1'b0;
      unique case (uw.op)
         OP_INIT: begin
            i_in    = '0;
            j_in    = '0;
            k_in    = '0;
            done_in = 1'b0;
         end
         OP_WR_RELAX: begin
            if (!j_last) begin
               j_in = j_ff + 1'b1;
            end else begin
               j_in = '0;
               if (!i_last) begin
                  i_in = i_ff + 1'b1;
               end else begin
                  i_in = '0;
                  k_in = k_last ? '0 : k_ff + 1'b1;
               end
            end
         end
         OP_ADV_I: i_in = i_last ? '0 : i_ff + 1'b1;
         OP_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               done_in  = i_last && j_last;
               if (!j_last) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  j_in = '0;
                  i_in = i_last ? '0 : i_ff + 1'b1;
               end
            end
         end
         OP_EMIT_NEG: out_load = out_free;
         default: ;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         vcnt_ff      <= VCNT_RESET;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         done_ff      <= 1'b0;
      end else begin
         step_ff <= step_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         k_ff    <= k_in;
         done_ff <= done_in;
         if (csr_wr_en) begin
            vcnt_ff <= csr_wr_data;
         end
         // Clear word drops every stored entry
         if (req_accept && (req_if.mode == MODE_CLEAR)) begin
            vld_ff <= '0;
         end else if (mem_we) begin
            vld_ff[mem_waddr] <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Matrix RAM: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      a_raw_ff  <= mem[addr_a];
      b_raw_ff  <= mem[addr_b];
      a_vld_ff  <= vld_ff[addr_a];
      b_vld_ff  <= vld_ff[addr_b];
      a_diag_ff <= (addr_a[AW-1:VW] == addr_a[VW-1:0]);
      b_diag_ff <= (addr_b[AW-1:VW] == addr_b[VW-1:0]);
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff <= req_if.mode;
         u_ff    <= req_if.source_vertex;
         v_ff    <= req_if.dest_vertex;
         w_ff    <= req_if.edge_weight;
      end
      if (uw.op == OP_SUM) begin
         sum_ff    <= sum_sat;
         sum_ok_ff <= !a_inf && !b_inf;
      end
      if (out_load) begin
         if (uw.op == OP_EMIT_NEG) begin
            row_ff  <= '0;
            col_ff  <= '0;
            len_ff  <= '0;
            unr_ff  <= 1'b0;
            neg_ff  <= 1'b1;
            last_ff <= 1'b1;
         end else begin
            row_ff  <= VTX_W'(i_ff);
            col_ff  <= VTX_W'(j_ff);
            len_ff  <= a_inf ? '0 : a_len;
            unr_ff  <= a_inf;
            neg_ff  <= 1'b0;
            last_ff <= i_last && j_last;
         end
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.row_vertex     = row_ff;
   assign rsp_if.col_vertex     = col_ff;
   assign rsp_if.path_length    = len_ff;
   assign rsp_if.unreachable    = unr_ff;
   assign rsp_if.negative_cycle = neg_ff;
   assign rsp_if.last           = last_ff;

   // Checks
   `APSP_ASSERT(a_neg_is_last, clock, reset, rsp_if.valid && rsp_if.negative_cycle,
      rsp_if.last && !rsp_if.unreachable, "negative cycle word must be a lone last word")
   `APSP_ASSERT(a_unr_zero, clock, reset, rsp_if.valid && rsp_if.unreachable,
      rsp_if.path_length == '0, "unreachable word must carry zero length")
   `APSP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_if.ready,
      "sequencer took two words back to back")
   `APSP_ASSERT(a_last_to_idle, clock, reset,
      (uw.op == OP_EMIT) && out_free && i_last && j_last, (##3 (step_ff == STEP_IDLE)),
      "sequencer did not return to idle after the last word")

endmodule

// ===== test/all_pairs_shortest_path_test.sv =====
module all_pairs_shortest_path_test;
   import apsp_pkg::*;

   localparam int MAX_VERTICES = MAX_VERTICES_DEF;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 185;
   localparam int QUIET_LIMIT = 20000;

   typedef struct {
      logic [VTX_W-1:0]        row;
      logic [VTX_W-1:0]        col;
      logic signed [LEN_W-1:0] len;
      logic                    unreachable;
      logic                    negative_cycle;
      logic                    last;
   } distance_entry_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [VCNT_W-1:0] csr_wr_data;

   apsp_req_if req_bus ();
   apsp_rsp_if rsp_bus ();

   all_pairs_shortest_path uut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Shadow of the block: distance matrix and vertex count register
   logic signed [LEN_W-1:0] dist_len [MAX_VERTICES][MAX_VERTICES];
   logic                    dist_inf [MAX_VERTICES][MAX_VERTICES];
   logic [VCNT_W-1:0]       vertex_count_reg;

   distance_entry_type pending_distances [$];
   int mismatch_count = 0;
   int burst_left = 0;

   function automatic void clear_distances();
      int r;
      int c;
      for (r = 0; r < MAX_VERTICES; r++) begin
         for (c = 0; c < MAX_VERTICES; c++) begin
            dist_len[r][c] = '0;
            dist_inf[r][c] = (r != c);
         end
      end
   endfunction

   function automatic int active_vertices();
      if (vertex_count_reg == '0) return 1;
      if (vertex_count_reg > MAX_VERTICES) return MAX_VERTICES;
      return int'(vertex_count_reg);
   endfunction

   // Apply one accepted word to the shadow matrix and queue the distances it yields
   function automatic void update_distances(input logic [MODE_W-1:0] mode,
                                            input logic [VTX_W-1:0] src,
                                            input logic [VTX_W-1:0] dst,
                                            input logic signed [WEIGHT_W-1:0] weight);
      int n;
      int i;
      int j;
      int k;
      logic signed [LEN_W-1:0] wide;
      logic signed [LEN_W:0] sum;
      logic signed [LEN_W-1:0] clipped;
      logic negative;
      distance_entry_type entry;
      n = active_vertices();
      case (mode)
         MODE_CLEAR: begin
            clear_distances();
         end
         MODE_LOAD: begin
            wide = LEN_W'(weight);
            if (src < n && dst < n) begin
               if (dist_inf[src][dst] || wide < dist_len[src][dst]) begin
                  dist_inf[src][dst] = 1'b0;
                  dist_len[src][dst] = wide;
               end
            end
         end
         MODE_RUN: begin
            // Relax through every intermediate vertex, clipping sums to 48 bits
            for (k = 0; k < n; k++) begin
               for (i = 0; i < n; i++) begin
                  for (j = 0; j < n; j++) begin
                     if (!dist_inf[i][k] && !dist_inf[k][j]) begin
                        sum = $signed({dist_len[i][k][LEN_W-1], dist_len[i][k]})
                            + $signed({dist_len[k][j][LEN_W-1], dist_len[k][j]});
                        if (sum[LEN_W] != sum[LEN_W-1])
                           clipped = sum[LEN_W] ? LEN_MIN : LEN_MAX;
                        else
                           clipped = sum[LEN_W-1:0];
                        if (dist_inf[i][j] || clipped < dist_len[i][j]) begin
                           dist_inf[i][j] = 1'b0;
                           dist_len[i][j] = clipped;
                        end
                     end
                  end
               end
            end
            negative = 1'b0;
            for (i = 0; i < n; i++) begin
               if (!dist_inf[i][i] && dist_len[i][i] < 0) negative = 1'b1;
            end
            if (negative) begin
               entry.row = '0;
               entry.col = '0;
               entry.len = '0;
               entry.unreachable = 1'b0;
               entry.negative_cycle = 1'b1;
               entry.last = 1'b1;
               pending_distances.push_back(entry);
            end else begin
               for (i = 0; i < n; i++) begin
                  for (j = 0; j < n; j++) begin
                     entry.row = VTX_W'(i);
                     entry.col = VTX_W'(j);
                     entry.len = dist_inf[i][j] ? '0 : dist_len[i][j];
                     entry.unreachable = dist_inf[i][j];
                     entry.negative_cycle = 1'b0;
                     entry.last = (i == n - 1) && (j == n - 1);
                     pending_distances.push_back(entry);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Send one request word in bursts with random gaps, predict on acceptance
   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [VTX_W-1:0] src,
                            input logic [VTX_W-1:0] dst,
                            input logic signed [WEIGHT_W-1:0] weight);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.source_vertex <= src;
      req_bus.dest_vertex <= dst;
      req_bus.edge_weight <= weight;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      update_distances(mode, src, dst, weight);
   endtask

   // Hold the sender until every expected distance is back and the block is idle
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_vertex_count(input logic [VCNT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      vertex_count_reg = value;
   endtask

   // Matrix straight out of reset, plus an unused mode word
   task automatic test_reset_state();
      send_word(MODE_RUN, '0, '0, '0);
      send_word(MODE_UNUSED, 3'd7, 3'd7, 16'sh7fff);
      send_word(MODE_RUN, 3'd7, 3'd7, 16'sh8000);
      drain_results();
   endtask

   // Extreme weights, parallel edges and diagonal edges on the full matrix
   task automatic test_edge_loads();
      write_vertex_count(4'd15);
      send_word(MODE_CLEAR, '0, '0, '0);
      send_word(MODE_LOAD, 3'd7, 3'd0, 16'sh7fff);
      send_word(MODE_LOAD, 3'd0, 3'd1, 16'sd100);
      send_word(MODE_LOAD, 3'd0, 3'd1, 16'sd50);
      send_word(MODE_LOAD, 3'd0, 3'd1, 16'sd200);
      send_word(MODE_LOAD, 3'd1, 3'd7, 16'sh8000);
      send_word(MODE_LOAD, 3'd3, 3'd3, 16'sd5);
      send_word(MODE_LOAD, 3'd2, 3'd2, 16'sd0);
      send_word(MODE_RUN, '0, '0, '0);
      drain_results();
   endtask

   // Out-of-range edges, the smallest vertex counts and a kept matrix
   task automatic test_vertex_limits();
      write_vertex_count(4'd4);
      send_word(MODE_CLEAR, '0, '0, '0);
      send_word(MODE_LOAD, 3'd5, 3'd1, 16'sd7);
      send_word(MODE_LOAD, 3'd1, 3'd4, 16'sd7);
      send_word(MODE_LOAD, 3'd3, 3'd0, -16'sd3);
      send_word(MODE_LOAD, 3'd0, 3'd3, 16'sd4);
      send_word(MODE_RUN, '0, '0, '0);
      drain_results();
      write_vertex_count(4'd0);
      send_word(MODE_RUN, '0, '0, '0);
      drain_results();
      write_vertex_count(4'd1);
      send_word(MODE_LOAD, 3'd0, 3'd0, -16'sd1);
      send_word(MODE_RUN, '0, '0, '0);
      drain_results();
      write_vertex_count(4'd8);
      send_word(MODE_RUN, '0, '0, '0);
      send_word(MODE_CLEAR, '0, '0, '0);
      send_word(MODE_RUN, '0, '0, '0);
      drain_results();
   endtask

   // Negative ring, rerun until lengths pin at the lower bound
   task automatic test_negative_saturation();
      int i;
      int j;
      int runs;
      logic pinned;
      send_word(MODE_CLEAR, '0, '0, '0);
      for (i = 0; i < MAX_VERTICES; i++)
         send_word(MODE_LOAD, VTX_W'(i), VTX_W'((i + 1) % MAX_VERTICES), 16'sh8000);
      runs = 0;
      pinned = 1'b0;
      while (!pinned && runs < 40) begin
         send_word(MODE_RUN, '0, '0, '0);
         runs++;
         for (i = 0; i < MAX_VERTICES; i++) begin
            for (j = 0; j < MAX_VERTICES; j++) begin
               if (!dist_inf[i][j] && dist_len[i][j] == LEN_MIN) pinned = 1'b1;
            end
         end
      end
      send_word(MODE_RUN, '0, '0, '0);
      drain_results();
   endtask

   // Random graphs: mostly clear, load, run sequences with some noise
   task automatic test_random_graphs();
      int words_left;
      int edge_total;
      int n;
      logic [VTX_W-1:0] u;
      logic [VTX_W-1:0] v;
      logic signed [WEIGHT_W-1:0] w;
      words_left = RANDOM_WORDS;
      while (words_left > 0) begin
         if ($urandom_range(0, 3) == 0) begin
            drain_results();
            case ($urandom_range(0, 9))
               0: write_vertex_count(VCNT_W'($urandom_range(0, 15)));
               1, 2: write_vertex_count(VCNT_W'(MAX_VERTICES));
               default: write_vertex_count(VCNT_W'($urandom_range(1, 6)));
            endcase
         end
         n = active_vertices();
         if ($urandom_range(0, 7) != 0) begin
            send_word(MODE_CLEAR, VTX_W'($urandom), VTX_W'($urandom), WEIGHT_W'($urandom));
            words_left--;
         end
         edge_total = $urandom_range(1, 2 * n + 2);
         repeat (edge_total) begin
            if ($urandom_range(0, 9) == 0) begin
               u = VTX_W'($urandom);
               v = VTX_W'($urandom);
            end else begin
               u = VTX_W'($urandom_range(0, n - 1));
               v = VTX_W'($urandom_range(0, n - 1));
            end
            case ($urandom_range(0, 9))
               0: w = WEIGHT_W'($urandom);
               1: w = WEIGHT_W'(-$urandom_range(1, 50));
               2: w = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
               default: w = WEIGHT_W'($urandom_range(0, 2000));
            endcase
            send_word(MODE_LOAD, u, v, w);
            words_left--;
            if ($urandom_range(0, 15) == 0)
               send_word(MODE_UNUSED, VTX_W'($urandom), VTX_W'($urandom), WEIGHT_W'($urandom));
         end
         if ($urandom_range(0, 9) != 0) begin
            send_word(MODE_RUN, VTX_W'($urandom), VTX_W'($urandom), WEIGHT_W'($urandom));
            words_left--;
         end
         if ($urandom_range(0, 5) == 0) drain_results();
      end
   endtask

   // Receiver stall pattern, style picked anew each time the phase counter wraps
   stall_style_type stall_style = STALL_NONE;
   logic [5:0] stall_phase = '0;
   logic sink_ready = 1'b0;
   assign rsp_bus.ready = sink_ready;

   always @(posedge clock) begin
      stall_phase <= stall_phase + 6'd1;
      if (stall_phase == '0) stall_style <= stall_style_type'($urandom_range(0, 3));
      case (stall_style)
         STALL_NONE: sink_ready <= 1'b1;
         STALL_COIN: sink_ready <= 1'($urandom_range(0, 1));
         STALL_PERIODIC: sink_ready <= (stall_phase[2:0] < 3'd5);
         default: sink_ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // Compare each accepted result word with the oldest expected distance
   always @(posedge clock) begin : check_results
      distance_entry_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_distances.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected result word: row %0d col %0d len %0d unr %0b neg %0b last %0b",
                        rsp_bus.row_vertex, rsp_bus.col_vertex, rsp_bus.path_length,
                        rsp_bus.unreachable, rsp_bus.negative_cycle, rsp_bus.last);
            mismatch_count++;
         end else begin
            want = pending_distances.pop_front();
            if (rsp_bus.row_vertex !== want.row || rsp_bus.col_vertex !== want.col ||
                rsp_bus.path_length !== want.len || rsp_bus.unreachable !== want.unreachable ||
                rsp_bus.negative_cycle !== want.negative_cycle || rsp_bus.last !== want.last) begin
               if (mismatch_count < 10) begin
                  $display("mismatch: expected row %0d col %0d len %0d unr %0b neg %0b last %0b",
                           want.row, want.col, want.len, want.unreachable,
                           want.negative_cycle, want.last);
                  $display("          actual   row %0d col %0d len %0d unr %0b neg %0b last %0b",
                           rsp_bus.row_vertex, rsp_bus.col_vertex, rsp_bus.path_length,
                           rsp_bus.unreachable, rsp_bus.negative_cycle, rsp_bus.last);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run after too long with no word moving on either side
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_CLEAR;
      req_bus.source_vertex = '0;
      req_bus.dest_vertex = '0;
      req_bus.edge_weight = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      vertex_count_reg = VCNT_RESET;
      clear_distances();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_edge_loads();
      test_vertex_limits();
      test_negative_saturation();
      test_random_graphs();
      drain_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_distances.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
